// File: rtl/thl_pkg.sv
// Shared constants, types and helpers for the thermistor table linearizer.
`timescale 1ns / 1ps

package thl_pkg;

    localparam int ENTRIES    = 32;
    localparam int NUM_TABLES = 4;
    localparam int ADC_BITS   = 10;

    localparam int ADC_W   = 10;
    localparam int TEMP_W  = 16;
    localparam int SLOPE_W = 16;
    localparam int TSEL_W  = 2;
    localparam int EIDX_W  = 5;
    localparam int CFG_W   = 6;
    localparam int CFG_IDX_W = 1;
    localparam int STAT_W  = 2;

    localparam int DEPTH  = NUM_TABLES * ENTRIES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int LEVELS = $clog2(ENTRIES);

    localparam logic [ADC_W-1:0] ADC_MASK = ADC_W'((64'd1 << ADC_BITS) - 64'd1);

    // interpolation arithmetic
    localparam int DIFF_W     = ADC_W + 1;
    localparam int PROD_W     = DIFF_W + TEMP_W + 1;
    localparam int NUM_W      = PROD_W + 2;
    localparam int TY_W       = TEMP_W + 6;
    localparam int DIV_BPS    = 4;
    localparam int DIV_STAGES = (NUM_W + DIV_BPS - 1) / DIV_BPS;
    localparam int DIV_QW     = DIV_STAGES * DIV_BPS;
    localparam int DEN_W      = ADC_W + 1;

    localparam logic KIND_CONVERT = 1'b0;
    localparam logic KIND_LOAD    = 1'b1;

    localparam logic FMT_PAIR   = 1'b0;
    localparam logic FMT_TRIPLE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_FORMAT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_USED = 1'd1;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_SAT  = 2'd1;
    localparam logic [STAT_W-1:0] ST_ZERO = 2'd2;

    typedef struct packed {
        logic              valid;
        logic [ADC_W-1:0]  x;
        logic [TSEL_W-1:0] tsel;
        logic [IDX_W-1:0]  lo;
        logic [IDX_W-1:0]  hi;
    } thl_ctx_t;

    typedef struct packed {
        logic                   zero;
        logic signed [TY_W-1:0] triple_y;
    } thl_side_t;

    function automatic logic [ADDR_W-1:0] thl_addr(input logic [TSEL_W-1:0] tsel,
                                                  input logic [IDX_W-1:0] idx);
        thl_addr = ADDR_W'(32'(tsel) * ENTRIES + 32'(idx));
    endfunction

endpackage

// File: rtl/thl_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module thl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/thl_search_level.sv
// One binary search step: breakpoint read, compare, narrow the bracket.
`timescale 1ns / 1ps

module thl_search_level import thl_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [ADC_W-1:0]  wdata,
    input  thl_ctx_t          ctx_in,
    output thl_ctx_t          ctx_out,
    output logic              active
);

    logic [IDX_W-1:0] mid;
    logic [IDX_W-1:0] mid_reg;
    logic [ADC_W-1:0] rdata;
    thl_ctx_t         ctx1_reg;
    thl_ctx_t         out_reg;
    thl_ctx_t         out_next;

    assign mid = ctx_in.lo + ((ctx_in.hi - ctx_in.lo) >> 1);

    thl_ram #(.WIDTH(ADC_W), .DEPTH(DEPTH)) u_adc (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (thl_addr(ctx_in.tsel, mid)),
        .rdata (rdata)
    );

    always_comb
    begin
        out_next = ctx1_reg;
        if ((ctx1_reg.hi - ctx1_reg.lo) > IDX_W'(1))
        begin
            if (rdata >= ctx1_reg.x)
            begin
                out_next.hi = mid_reg;
            end
            else
            begin
                out_next.lo = mid_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctx1_reg <= '0;
            out_reg  <= '0;
        end
        else
        begin
            ctx1_reg <= ctx_in;
            out_reg  <= out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mid_reg <= mid;
    end

    assign ctx_out = out_reg;
    assign active  = ctx1_reg.valid | out_reg.valid;

endmodule

// File: rtl/thl_div.sv
// Pipelined restoring divider on magnitudes, a few quotient bits per stage.
`timescale 1ns / 1ps

module thl_div import thl_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [DIV_QW-1:0] in_num,
    input  logic [DEN_W-1:0]  in_den,
    input  logic              in_neg,
    input  thl_side_t         in_side,
    output logic              out_valid,
    output logic [DIV_QW-1:0] out_quot,
    output logic              out_neg,
    output thl_side_t         out_side,
    output logic              active
);

    localparam int REM_W = DEN_W + 1;

    logic              valid_reg [DIV_STAGES];
    logic [DIV_QW-1:0] nq_reg    [DIV_STAGES];
    logic [REM_W-1:0]  rem_reg   [DIV_STAGES];
    logic [DEN_W-1:0]  den_reg   [DIV_STAGES];
    logic              neg_reg   [DIV_STAGES];
    thl_side_t         side_reg  [DIV_STAGES];
    logic [DIV_QW-1:0] nq_next   [DIV_STAGES];
    logic [REM_W-1:0]  rem_next  [DIV_STAGES];
    logic [DIV_STAGES-1:0] valid_vec;

    // numerator and quotient share one shift register
    always_comb
    begin
        logic [DIV_QW-1:0] nq;
        logic [REM_W-1:0]  rem;
        logic [DEN_W-1:0]  den;
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            if (s == 0)
            begin
                nq  = in_num;
                rem = '0;
                den = in_den;
            end
            else
            begin
                nq  = nq_reg[s-1];
                rem = rem_reg[s-1];
                den = den_reg[s-1];
            end
            for (int b = 0; b < DIV_BPS; b++)
            begin
                rem = {rem[REM_W-2:0], nq[DIV_QW-1]};
                nq  = {nq[DIV_QW-2:0], 1'b0};
                if (rem >= REM_W'(den))
                begin
                    rem   = rem - REM_W'(den);
                    nq[0] = 1'b1;
                end
            end
            nq_next[s]  = nq;
            rem_next[s] = rem;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < DIV_STAGES; s++)
            begin
                valid_reg[s] <= 1'b0;
            end
        end
        else
        begin
            for (int s = 0; s < DIV_STAGES; s++)
            begin
                valid_reg[s] <= (s == 0) ? in_valid : valid_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            nq_reg[s]  <= nq_next[s];
            rem_reg[s] <= rem_next[s];
            if (s == 0)
            begin
                den_reg[s]  <= in_den;
                neg_reg[s]  <= in_neg;
                side_reg[s] <= in_side;
            end
            else
            begin
                den_reg[s]  <= den_reg[s-1];
                neg_reg[s]  <= neg_reg[s-1];
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    always_comb
    begin
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            valid_vec[s] = valid_reg[s];
        end
    end

    assign out_valid = valid_reg[DIV_STAGES-1];
    assign out_quot  = nq_reg[DIV_STAGES-1];
    assign out_neg   = neg_reg[DIV_STAGES-1];
    assign out_side  = side_reg[DIV_STAGES-1];
    assign active    = |valid_vec;

endmodule

// File: rtl/thermistor_table_linearizer.sv
// Top level: table load, pipelined binary search, interpolation and saturation.
`timescale 1ns / 1ps

// A convert transfer yields one result on temperature/status with a one-cycle
// done strobe. On its way the convert passes the context register (loaded at
// the transfer edge), 2 registers per search level, 1 for the bracket read, 2
// arithmetic, 8 divider stages and 1 output register; the result cannot be
// held off.
// Converts stream at one per cycle, the path being one read port per search
// level and a pipelined divider. A load writes its entry at the transfer edge
// and is held off by busy while converts are in flight, so a load waits until
// the pipeline has drained. Loads give no result.

module thermistor_table_linearizer import thl_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 kind,
    input  logic [TSEL_W-1:0]    table_select,
    input  logic [ADC_W-1:0]     adc_reading,
    input  logic [EIDX_W-1:0]    entry_index,
    input  logic [ADC_W-1:0]     entry_adc,
    input  logic [TEMP_W-1:0]    entry_temp,
    input  logic [SLOPE_W-1:0]   entry_slope,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output logic                 done,
    output logic [TEMP_W-1:0]    temperature,
    output logic [STAT_W-1:0]    status
);

    logic             table_format_reg;
    logic [CFG_W-1:0] entries_used_reg;

    logic              accept;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADC_W-1:0]  wr_adc;
    logic [TSEL_W-1:0] tsel_conv;
    logic [CNT_W-1:0]  n_clamped;
    thl_ctx_t          ctx0_next;
    thl_ctx_t          ctx0_reg;

    thl_ctx_t          ctx_chain [LEVELS+1];
    logic [LEVELS-1:0] level_active;

    thl_ctx_t           ctx_rd_reg;
    logic [ADC_W-1:0]   xl;
    logic [ADC_W-1:0]   xh;
    logic [TEMP_W-1:0]  yl;
    logic [TEMP_W-1:0]  yh;
    logic [SLOPE_W-1:0] dh;

    logic signed [DIFF_W-1:0] dlo;
    logic signed [DIFF_W-1:0] dhi;
    logic signed [DIFF_W-1:0] dxh;
    logic                     mul_valid_reg;
    logic signed [PROD_W-1:0] ph_reg;
    logic signed [PROD_W-1:0] pl_reg;
    logic signed [PROD_W-1:0] pt_reg;
    logic signed [DEN_W-1:0]  den_reg;
    logic [TEMP_W-1:0]        yh_reg;

    logic signed [NUM_W-1:0]    num;
    logic signed [PROD_W:0]     pt_round;
    logic                       add_valid_reg;
    logic [DIV_QW-1:0]          num_mag_reg;
    logic [DEN_W-1:0]           den_mag_reg;
    logic                       neg_reg;
    thl_side_t                  side_reg;
    thl_side_t                  side_next;

    logic              div_valid;
    logic [DIV_QW-1:0] div_quot;
    logic              div_neg;
    thl_side_t         div_side;
    logic              div_active;

    logic                done_reg;
    logic [TEMP_W-1:0]   temperature_reg;
    logic [STAT_W-1:0]   status_reg;
    logic [TEMP_W-1:0]   temperature_next;
    logic [STAT_W-1:0]   status_next;

    logic in_flight;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_format_reg <= FMT_TRIPLE;
            entries_used_reg <= CFG_W'(ENTRIES);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TABLE_FORMAT: table_format_reg <= cfg_data[0];
                CFG_ENTRIES_USED: entries_used_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign in_flight = ctx0_reg.valid | (|level_active) | ctx_rd_reg.valid | mul_valid_reg
                       | add_valid_reg | div_active;
    // a load may not overtake reads of converts still in the search
    assign busy   = (kind == KIND_LOAD) & in_flight;
    assign accept = start & ~busy;

    assign wr_en   = accept & (kind == KIND_LOAD) & (32'(table_select) < NUM_TABLES)
                     & (32'(entry_index) < ENTRIES);
    assign wr_addr = thl_addr(table_select, IDX_W'(entry_index));
    assign wr_adc  = entry_adc & ADC_MASK;

    always_comb
    begin
        if (32'(table_select) >= NUM_TABLES)
        begin
            tsel_conv = TSEL_W'(NUM_TABLES - 1);
        end
        else
        begin
            tsel_conv = table_select;
        end
        priority if (entries_used_reg < CFG_W'(2))
        begin
            n_clamped = CNT_W'(2);
        end
        else if (32'(entries_used_reg) > ENTRIES)
        begin
            n_clamped = CNT_W'(ENTRIES);
        end
        else
        begin
            n_clamped = CNT_W'(entries_used_reg);
        end
        ctx0_next.valid = accept & (kind == KIND_CONVERT);
        ctx0_next.x     = adc_reading & ADC_MASK;
        ctx0_next.tsel  = tsel_conv;
        ctx0_next.lo    = '0;
        ctx0_next.hi    = IDX_W'(n_clamped - CNT_W'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctx0_reg <= '0;
        end
        else
        begin
            ctx0_reg <= ctx0_next;
        end
    end

    assign ctx_chain[0] = ctx0_reg;

    for (genvar l = 0; l < LEVELS; l++)
    begin : g_level
        thl_search_level u_level (
            .clk     (clk),
            .rst_n   (rst_n),
            .we      (wr_en),
            .waddr   (wr_addr),
            .wdata   (wr_adc),
            .ctx_in  (ctx_chain[l]),
            .ctx_out (ctx_chain[l+1]),
            .active  (level_active[l])
        );
    end

    // bracket read
    thl_ram #(.WIDTH(ADC_W), .DEPTH(DEPTH)) u_adc_lo (
        .clk (clk), .we (wr_en), .waddr (wr_addr), .wdata (wr_adc),
        .raddr (thl_addr(ctx_chain[LEVELS].tsel, ctx_chain[LEVELS].lo)), .rdata (xl)
    );
    thl_ram #(.WIDTH(ADC_W), .DEPTH(DEPTH)) u_adc_hi (
        .clk (clk), .we (wr_en), .waddr (wr_addr), .wdata (wr_adc),
        .raddr (thl_addr(ctx_chain[LEVELS].tsel, ctx_chain[LEVELS].hi)), .rdata (xh)
    );
    thl_ram #(.WIDTH(TEMP_W), .DEPTH(DEPTH)) u_temp_lo (
        .clk (clk), .we (wr_en), .waddr (wr_addr), .wdata (entry_temp),
        .raddr (thl_addr(ctx_chain[LEVELS].tsel, ctx_chain[LEVELS].lo)), .rdata (yl)
    );
    thl_ram #(.WIDTH(TEMP_W), .DEPTH(DEPTH)) u_temp_hi (
        .clk (clk), .we (wr_en), .waddr (wr_addr), .wdata (entry_temp),
        .raddr (thl_addr(ctx_chain[LEVELS].tsel, ctx_chain[LEVELS].hi)), .rdata (yh)
    );
    thl_ram #(.WIDTH(SLOPE_W), .DEPTH(DEPTH)) u_slope_hi (
        .clk (clk), .we (wr_en), .waddr (wr_addr), .wdata (entry_slope),
        .raddr (thl_addr(ctx_chain[LEVELS].tsel, ctx_chain[LEVELS].hi)), .rdata (dh)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctx_rd_reg    <= '0;
            mul_valid_reg <= 1'b0;
            add_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            ctx_rd_reg    <= ctx_chain[LEVELS];
            mul_valid_reg <= ctx_rd_reg.valid;
            add_valid_reg <= mul_valid_reg;
            done_reg      <= div_valid;
        end
    end

    // multiply stage
    assign dlo = $signed({1'b0, ctx_rd_reg.x}) - $signed({1'b0, xl});
    assign dhi = $signed({1'b0, xh}) - $signed({1'b0, ctx_rd_reg.x});
    assign dxh = $signed({1'b0, ctx_rd_reg.x}) - $signed({1'b0, xh});

    always_ff @(posedge clk)
    begin
        ph_reg  <= dlo * $signed({1'b0, yh});
        pl_reg  <= dhi * $signed({1'b0, yl});
        pt_reg  <= dxh * $signed({1'b0, dh});
        den_reg <= $signed({1'b0, xh}) - $signed({1'b0, xl});
        yh_reg  <= yh;
    end

    // add stage: pair numerator, triple result, sign split for the divider
    assign num      = NUM_W'(ph_reg) + NUM_W'(pl_reg);
    assign pt_round = (PROD_W+1)'(pt_reg) + (PROD_W+1)'(128);

    always_comb
    begin
        side_next.zero     = (den_reg == '0);
        side_next.triple_y = TY_W'($signed({1'b0, yh_reg})) - TY_W'(pt_round >>> 8);
    end

    always_ff @(posedge clk)
    begin
        num_mag_reg <= DIV_QW'(num[NUM_W-1] ? -num : num);
        den_mag_reg <= DEN_W'(den_reg[DEN_W-1] ? -den_reg : den_reg);
        neg_reg     <= num[NUM_W-1] ^ den_reg[DEN_W-1];
        side_reg    <= side_next;
    end

    thl_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (add_valid_reg),
        .in_num    (num_mag_reg),
        .in_den    (den_mag_reg),
        .in_neg    (neg_reg),
        .in_side   (side_reg),
        .out_valid (div_valid),
        .out_quot  (div_quot),
        .out_neg   (div_neg),
        .out_side  (div_side),
        .active    (div_active)
    );

    // saturation and output
    always_comb
    begin
        temperature_next = '0;
        status_next      = ST_OK;
        priority if (table_format_reg == FMT_TRIPLE)
        begin
            priority if (div_side.triple_y < 0)
            begin
                status_next = ST_SAT;
            end
            else if (div_side.triple_y > $signed(TY_W'(65535)))
            begin
                temperature_next = '1;
                status_next      = ST_SAT;
            end
            else
            begin
                temperature_next = div_side.triple_y[TEMP_W-1:0];
            end
        end
        else if (div_side.zero)
        begin
            status_next = ST_ZERO;
        end
        else if (div_neg && (div_quot != '0))
        begin
            status_next = ST_SAT;
        end
        else if (div_quot > DIV_QW'(65535))
        begin
            temperature_next = '1;
            status_next      = ST_SAT;
        end
        else
        begin
            temperature_next = div_quot[TEMP_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        temperature_reg <= temperature_next;
        status_reg      <= status_next;
    end

    assign done        = done_reg;
    assign temperature = temperature_reg;
    assign status      = status_reg;

endmodule

// File: bench/tb_thermistor_table_linearizer.sv
// Self-checking testbench for the thermistor table linearizer.
`timescale 1ns / 1ps

module tb_thermistor_table_linearizer;
    import thl_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 40;

    typedef enum logic [1:0] {OP_CONVERT, OP_LOAD, OP_CONFIG} op_e;

    typedef struct {
        op_e                op;
        logic [TSEL_W-1:0]  tsel;
        logic [ADC_W-1:0]   x;
        logic [EIDX_W-1:0]  idx;
        logic [ADC_W-1:0]   eadc;
        logic [TEMP_W-1:0]  etemp;
        logic [SLOPE_W-1:0] eslope;
        bit                 typed;
        logic [TEMP_W-1:0]  want_temp;
        logic [STAT_W-1:0]  want_stat;
    } stim_row_t;

    typedef struct {
        logic [TEMP_W-1:0] temp;
        logic [STAT_W-1:0] stat;
    } reading_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic                 kind;
    logic [TSEL_W-1:0]    table_select;
    logic [ADC_W-1:0]     adc_reading;
    logic [EIDX_W-1:0]    entry_index;
    logic [ADC_W-1:0]     entry_adc;
    logic [TEMP_W-1:0]    entry_temp;
    logic [SLOPE_W-1:0]   entry_slope;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 done;
    logic [TEMP_W-1:0]    temperature;
    logic [STAT_W-1:0]    status;

    thermistor_table_linearizer u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .kind(kind),
        .table_select(table_select), .adc_reading(adc_reading),
        .entry_index(entry_index), .entry_adc(entry_adc), .entry_temp(entry_temp),
        .entry_slope(entry_slope), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .done(done), .temperature(temperature), .status(status)
    );

    // shadow of the breakpoint store and registers
    logic [ADC_W-1:0]   bp_adc   [DEPTH];
    logic [TEMP_W-1:0]  bp_temp  [DEPTH];
    logic [SLOPE_W-1:0] bp_slope [DEPTH];
    logic               fmt_mode;
    logic [CFG_W-1:0]   search_len;

    reading_t  pending_readings[$];
    stim_row_t directed_rows[$];
    int        mismatches;
    int        n_convert;
    int        n_load;
    int        n_results;
    int        idle_cycles;

    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic reading_t interpolate(input logic [TSEL_W-1:0] tsel,
                                             input logic [ADC_W-1:0] reading);
        reading_t r;
        int     n;
        int     lo;
        int     hi;
        int     mid;
        int     base;
        longint x;
        longint xl;
        longint xh;
        longint yl;
        longint yh;
        longint v;
        longint y;
        base = int'(tsel) * ENTRIES;
        x = longint'(reading);
        n = int'(search_len);
        if (n < 2) n = 2;
        if (n > ENTRIES) n = ENTRIES;
        lo = 0;
        hi = n - 1;
        while (hi - lo > 1)
        begin
            mid = lo + (hi - lo) / 2;
            if (longint'(bp_adc[base + mid]) >= x) hi = mid;
            else lo = mid;
        end
        xl = longint'(bp_adc[base + lo]);
        xh = longint'(bp_adc[base + hi]);
        yl = longint'(bp_temp[base + lo]);
        yh = longint'(bp_temp[base + hi]);
        r.stat = ST_OK;
        if (fmt_mode == FMT_TRIPLE)
        begin
            v = (x - xh) * longint'(bp_slope[base + hi]) + 128;
            // floor division, not truncation
            y = yh - ((v >= 0) ? v / 256 : -((-v + 255) / 256));
        end
        else
        begin
            if (xh == xl)
            begin
                r.temp = '0;
                r.stat = ST_ZERO;
                return r;
            end
            y = ((x - xl) * yh + (xh - x) * yl) / (xh - xl);
        end
        if (y < 0)
        begin
            y = 0;
            r.stat = ST_SAT;
        end
        else if (y > 65535)
        begin
            y = 65535;
            r.stat = ST_SAT;
        end
        r.temp = TEMP_W'(y);
        return r;
    endfunction

    function automatic stim_row_t mk_row(op_e op, int tsel, int x, int idx, int eadc,
                                         int etemp, int eslope, bit typed,
                                         int want_temp, logic [STAT_W-1:0] want_stat);
        stim_row_t s;
        s.op = op;
        s.tsel = TSEL_W'(tsel);
        s.x = ADC_W'(x);
        s.idx = EIDX_W'(idx);
        s.eadc = ADC_W'(eadc);
        s.etemp = TEMP_W'(etemp);
        s.eslope = SLOPE_W'(eslope);
        s.typed = typed;
        s.want_temp = TEMP_W'(want_temp);
        s.want_stat = want_stat;
        return s;
    endfunction

    task automatic wait_drained();
        while (pending_readings.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        wait_drained();
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        if (idx == CFG_TABLE_FORMAT) fmt_mode = val[0];
        else search_len = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Drives one transfer; returns after the accepting edge.
    task automatic issue(input stim_row_t s);
        reading_t r;
        int       a;
        @(negedge clk);
        start = 1'b1;
        kind = (s.op == OP_LOAD) ? KIND_LOAD : KIND_CONVERT;
        table_select = s.tsel;
        adc_reading = s.x;
        entry_index = s.idx;
        entry_adc = s.eadc;
        entry_temp = s.etemp;
        entry_slope = s.eslope;
        do @(posedge clk); while (busy);
        if (s.op == OP_LOAD)
        begin
            a = int'(s.tsel) * ENTRIES + int'(s.idx);
            bp_adc[a] = s.eadc;
            bp_temp[a] = s.etemp;
            bp_slope[a] = s.eslope;
            n_load++;
        end
        else
        begin
            r = interpolate(s.tsel, s.x);
            if (s.typed && (r.temp !== s.want_temp || r.stat !== s.want_stat))
                $display("note: typed expectation %0d/%0d differs from predictor %0d/%0d",
                         s.want_temp, s.want_stat, r.temp, r.stat);
            if (s.typed)
            begin
                r.temp = s.want_temp;
                r.stat = s.want_stat;
            end
            pending_readings.push_back(r);
            n_convert++;
        end
    endtask

    task automatic idle_gap();
        int g;
        int p;
        p = $urandom_range(0, 99);
        if (p < 60) g = 0;
        else if (p < 95) g = $urandom_range(1, 3);
        else g = $urandom_range(10, 40);
        if (g > 0)
        begin
            @(negedge clk);
            start = 1'b0;
            repeat (g - 1) @(negedge clk);
        end
    endtask

    function automatic stim_row_t random_item(bit quiet);
        stim_row_t s;
        int idx;
        int p;
        idx = $urandom_range(0, ENTRIES - 1);
        s = mk_row($urandom_range(0, 99) < 25 ? OP_LOAD : OP_CONVERT,
                   $urandom_range(0, NUM_TABLES - 1), 0, idx, 0,
                   $urandom_range(0, 65535), $urandom_range(0, 65535), 1'b0, 0, ST_OK);
        p = $urandom_range(0, 99);
        if (p < 5) s.x = '0;
        else if (p < 10) s.x = '1;
        else s.x = ADC_W'($urandom_range(0, 1023));
        // mostly ascending breakpoints, sometimes anything
        if ($urandom_range(0, 99) < 85) s.eadc = ADC_W'(idx * 32 + $urandom_range(0, 31));
        else s.eadc = ADC_W'($urandom_range(0, 1023));
        if (quiet) s.eslope = SLOPE_W'($urandom_range(0, 2000));
        return s;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        reading_t w;
        if (rst_n && done)
        begin
            n_results++;
            if (pending_readings.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result temp=%0d status=%0d", temperature, status);
            end
            else
            begin
                w = pending_readings.pop_front();
                if (temperature !== w.temp || status !== w.stat)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: result %0d: expected temp=%0d status=%0d, got temp=%0d status=%0d",
                                 n_results, w.temp, w.stat, temperature, status);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        int t;
        int i;
        int ph;
        int k;
        logic [CFG_W-1:0] len_choice [7];
        start = 1'b0;
        kind = KIND_CONVERT;
        table_select = '0;
        adc_reading = '0;
        entry_index = '0;
        entry_adc = '0;
        entry_temp = '0;
        entry_slope = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_TABLE_FORMAT;
        cfg_data = '0;
        fmt_mode = FMT_TRIPLE;
        search_len = 6'd32;
        mismatches = 0;
        n_convert = 0;
        n_load = 0;
        n_results = 0;
        len_choice = '{6'd0, 6'd1, 6'd2, 6'd32, 6'd33, 6'd63, 6'd5};
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // every entry is written before any convert can read it
        for (t = 0; t < NUM_TABLES; t++)
            for (i = 0; i < ENTRIES; i++)
            begin
                case (t)
                    0: issue(mk_row(OP_LOAD, t, 0, i, i * 32, i * 100, 25600, 0, 0, ST_OK));
                    1: issue(mk_row(OP_LOAD, t, 0, i, i * 32, 65535, 65535, 0, 0, ST_OK));
                    2: issue(mk_row(OP_LOAD, t, 0, i, 500, $urandom_range(0, 65535),
                                    $urandom_range(0, 65535), 0, 0, ST_OK));
                    default: issue(mk_row(OP_LOAD, t, 0, i, i * 32 + $urandom_range(0, 31),
                                          $urandom_range(0, 65535), $urandom_range(0, 3000),
                                          0, 0, ST_OK));
                endcase
                idle_gap();
            end

        directed_rows.push_back(mk_row(OP_CONVERT, 0, 0, 0, 0, 0, 0, 0, 0, ST_OK));
        directed_rows.push_back(mk_row(OP_CONVERT, 0, 1023, 0, 0, 0, 0, 1, 0, ST_OK));
        directed_rows.push_back(mk_row(OP_CONVERT, 1, 0, 0, 0, 0, 0, 1, 65535, ST_SAT));
        directed_rows.push_back(mk_row(OP_CONVERT, 3, 512, 0, 0, 0, 0, 0, 0, ST_OK));
        directed_rows.push_back(mk_row(OP_LOAD, 0, 0, 31, 992, 3100, 65535, 0, 0, ST_OK));
        directed_rows.push_back(mk_row(OP_CONVERT, 0, 1023, 0, 0, 0, 0, 1, 0, ST_SAT));
        directed_rows.push_back(mk_row(OP_CONFIG, 0, 0, CFG_ENTRIES_USED, 0, 0, 0, 0, 0, ST_OK));
        directed_rows.push_back(mk_row(OP_CONVERT, 0, 700, 0, 0, 0, 0, 0, 0, ST_OK));
        directed_rows.push_back(mk_row(OP_CONFIG, 0, 63, CFG_ENTRIES_USED, 0, 0, 0, 0, 0, ST_OK));
        directed_rows.push_back(mk_row(OP_CONVERT, 3, 1, 0, 0, 0, 0, 0, 0, ST_OK));
        directed_rows.push_back(mk_row(OP_CONFIG, 0, 2, CFG_ENTRIES_USED, 0, 0, 0, 0, 0, ST_OK));
        directed_rows.push_back(mk_row(OP_CONVERT, 0, 1023, 0, 0, 0, 0, 0, 0, ST_OK));
        directed_rows.push_back(mk_row(OP_CONFIG, 0, FMT_PAIR, CFG_TABLE_FORMAT, 0, 0, 0,
                                       0, 0, ST_OK));
        directed_rows.push_back(mk_row(OP_CONVERT, 2, 500, 0, 0, 0, 0, 1, 0, ST_ZERO));
        directed_rows.push_back(mk_row(OP_CONVERT, 0, 0, 0, 0, 0, 0, 0, 0, ST_OK));
        directed_rows.push_back(mk_row(OP_CONVERT, 0, 1023, 0, 0, 0, 0, 0, 0, ST_OK));
        directed_rows.push_back(mk_row(OP_CONVERT, 1, 5, 0, 0, 0, 0, 0, 0, ST_OK));
        directed_rows.push_back(mk_row(OP_CONFIG, 0, 32, CFG_ENTRIES_USED, 0, 0, 0, 0, 0, ST_OK));
        directed_rows.push_back(mk_row(OP_CONVERT, 3, 1023, 0, 0, 0, 0, 0, 0, ST_OK));
        directed_rows.push_back(mk_row(OP_CONVERT, 2, 300, 0, 0, 0, 0, 1, 0, ST_ZERO));
        directed_rows.push_back(mk_row(OP_CONFIG, 0, FMT_TRIPLE, CFG_TABLE_FORMAT, 0, 0, 0,
                                       0, 0, ST_OK));
        directed_rows.push_back(mk_row(OP_CONVERT, 2, 300, 0, 0, 0, 0, 0, 0, ST_OK));

        foreach (directed_rows[j])
        begin
            if (directed_rows[j].op == OP_CONFIG)
            begin
                @(negedge clk);
                start = 1'b0;
                write_reg(CFG_IDX_W'(directed_rows[j].idx), CFG_W'(directed_rows[j].x));
            end
            else
            begin
                issue(directed_rows[j]);
                idle_gap();
            end
        end

        for (ph = 0; ph < 7; ph++)
        begin
            @(negedge clk);
            start = 1'b0;
            // sender holds off until the pipeline has drained
            write_reg(CFG_TABLE_FORMAT, CFG_W'(ph == 6 ? $urandom_range(0, 1) : ph % 2));
            write_reg(CFG_ENTRIES_USED, len_choice[ph]);
            for (k = 0; k < 80; k++)
            begin
                issue(random_item(ph % 3 == 0));
                // stretches with no gaps at all
                if (k < 30 || k >= 60) idle_gap();
            end
        end
        @(negedge clk);
        start = 1'b0;

        while (pending_readings.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Covered %0d table loads and %0d conversions (%0d results) in both formats,",
                 n_load, n_convert, n_results);
        $display("search lengths from below the minimum to above the table size.");
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: filelist.f
rtl/thl_pkg.sv
rtl/thl_ram.sv
rtl/thl_search_level.sv
rtl/thl_div.sv
rtl/thermistor_table_linearizer.sv
bench/tb_thermistor_table_linearizer.sv
